// ===== rtl/core/ctp_pkg.sv =====
// shared types, codes and constants of the call timing profiler
package ctp_pkg;

    localparam int BINS_DEF         = 4096;
    localparam int ALIGN_SHIFT_DEF  = 4;
    localparam int STACK_DEPTH_DEF  = 1024;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [15:0] SLACK_PAIR_RST   = 16'd120;
    localparam logic [15:0] SLACK_CALLER_RST = 16'd100;

    localparam int ADDR_W    = 32;
    localparam int TS_W      = 64;
    localparam int IDX_W     = 12;
    localparam int COUNT_W   = 32;
    localparam int TIME_W    = 64;
    localparam int SLACK_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int BIN_W     = COUNT_W + TIME_W;

    typedef enum logic [1:0] {
        ACT_ENTRY = 2'd0,
        ACT_EXIT  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_DISABLED  = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_OVERFLOW  = 3'd3,
        STAT_OUTSIDE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_ENABLED      = 2'd0,
        CFG_SLACK_PAIR   = 2'd1,
        CFG_SLACK_CALLER = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_POP,
        S_CORR,
        S_ELAP,
        S_REC,
        S_BIN_RD,
        S_BIN_DATA,
        S_OUT
    } state_t;

    // decoded event handed from the front to the back
    typedef struct packed {
        action_t            kind;
        logic [ADDR_W-1:0]  faddr;
        logic [TS_W-1:0]    ts;
        logic [IDX_W-1:0]   idx;
        logic               idx_ok;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TS_W-1:0]    start;
        logic [TS_W-1:0]    slack;
    } frame_t;

    typedef struct packed {
        logic [TIME_W-1:0]  total;
        logic [COUNT_W-1:0] count;
    } bin_t;

    typedef struct packed {
        status_t            status;
        logic [TIME_W-1:0]  elapsed;
        logic [COUNT_W-1:0] rd_count;
        logic [TIME_W-1:0]  rd_time;
        logic [ADDR_W-1:0]  rd_addr;
        logic               base_valid;
    } res_t;

endpackage

// ===== rtl/core/ctp_ram.sv =====
// generic single-write, single-read ram with registered read
module ctp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/ctp_front.sv =====
// input side: accepts events, decodes them and pushes them into the queue
module ctp_front #(
    parameter int BINS = ctp_pkg::BINS_DEF
) (
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [111:0]             s_axis_tdata,
    input  logic [1:0]               s_axis_tuser,
    input  logic                     q_full,
    output logic                     q_push,
    output ctp_pkg::cmd_t            q_cmd
);

    logic [31:0] idx_ext;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_cmd.kind  = ctp_pkg::action_t'(s_axis_tuser);
        q_cmd.faddr = s_axis_tdata[31:0];
        q_cmd.ts    = s_axis_tdata[95:32];
        q_cmd.idx   = s_axis_tdata[107:96];
        idx_ext     = 32'(s_axis_tdata[107:96]);
        // reads beyond the window are flagged here so the back never touches the ram
        q_cmd.idx_ok = (q_cmd.kind == ctp_pkg::ACT_READ) ? (idx_ext < 32'(BINS)) : 1'b1;
    end

endmodule

// ===== rtl/core/ctp_fifo.sv =====
// short queue between the front and the back
module ctp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/ctp_back.sv =====
// back side: call stack, overhead correction, bin window and result register
module ctp_back #(
    parameter int BINS        = ctp_pkg::BINS_DEF,
    parameter int ALIGN_SHIFT = ctp_pkg::ALIGN_SHIFT_DEF,
    parameter int STACK_DEPTH = ctp_pkg::STACK_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         enabled,
    input  logic [ctp_pkg::SLACK_W-1:0]  slack_per_pair,
    input  logic [ctp_pkg::SLACK_W-1:0]  caller_share,
    input  logic                         q_empty,
    input  ctp_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ctp_pkg::res_t                out_res
);

    localparam int BA_W  = $clog2(BINS);
    localparam int CL_W  = $clog2(BINS + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int SL_W  = $clog2(STACK_DEPTH + 1);
    localparam int KEY_W = 32 - ALIGN_SHIFT;

    ctp_pkg::state_t state_reg, state_next;
    ctp_pkg::state_t clr_ret_reg, clr_ret_next;
    ctp_pkg::cmd_t   cmd_reg, cmd_next;
    ctp_pkg::res_t   res_reg, res_next;
    ctp_pkg::res_t   out_res_reg, out_res_next;
    logic            out_valid_reg, out_valid_next;

    logic [SL_W-1:0]  level_reg, level_next;
    logic [63:0]      slack_total_reg, slack_total_next;
    logic [KEY_W-1:0] window_base_reg, window_base_next;
    logic             base_known_reg, base_known_next;
    logic [BA_W-1:0]  phys_base_reg, phys_base_next;
    logic [BA_W-1:0]  clr_ptr_reg, clr_ptr_next;
    logic [CL_W-1:0]  clr_left_reg, clr_left_next;
    logic [BA_W-1:0]  off_reg, off_next;
    logic [BA_W-1:0]  phys_reg, phys_next;
    logic [31:0]      faddr_reg, faddr_next;
    logic [63:0]      dur_reg, dur_next;
    logic [63:0]      fslack_reg, fslack_next;
    logic [63:0]      x_reg, x_next;
    logic [63:0]      y_reg, y_next;

    // stack ram
    logic             stk_we, stk_re;
    logic [SA_W-1:0]  stk_waddr, stk_raddr;
    ctp_pkg::frame_t  stk_wdata, stk_rdata;
    // bin ram
    logic             bin_we, bin_re;
    logic [BA_W-1:0]  bin_waddr, bin_raddr;
    ctp_pkg::bin_t    bin_wdata, bin_rdata;

    // decision helpers
    logic [SL_W-1:0]  level_m1;
    logic             load_out;
    logic [KEY_W-1:0] key, base_eff, key_gap;
    logic             below, shift_small;
    logic [BA_W-1:0]  key_gap_lo;
    logic [BA_W:0]    phys_dn_wrap;
    logic [BA_W-1:0]  phys_dn;
    logic [BA_W:0]    phys_sum;
    logic [BA_W-1:0]  phys_rd;
    logic [BA_W:0]    clr_sum;
    logic [BA_W-1:0]  clr_inc;
    logic [31:0]      rd_addr_sum;

    ctp_ram #(.WIDTH($bits(ctp_pkg::frame_t)), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    ctp_ram #(.WIDTH(ctp_pkg::BIN_W), .DEPTH(BINS)) u_bins (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .re    (bin_re),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign level_m1  = level_reg - SL_W'(1);
    assign load_out  = (state_reg == ctp_pkg::S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        key      = KEY_W'(faddr_reg >> ALIGN_SHIFT);
        base_eff = base_known_reg ? window_base_reg : key;
        below    = key < base_eff;
        key_gap  = below ? (base_eff - key) : (key - base_eff);
        shift_small = 32'(key_gap) < 32'(BINS);
        key_gap_lo = key_gap[BA_W-1:0];
        // window moves down: logical bin 0 lands key_gap entries earlier in the ram
        phys_dn_wrap = {1'b0, phys_base_reg} + (BA_W + 1)'(BINS) - {1'b0, key_gap_lo};
        phys_dn  = (phys_base_reg >= key_gap_lo) ? (phys_base_reg - key_gap_lo)
                                                 : phys_dn_wrap[BA_W-1:0];
        phys_sum = {1'b0, phys_base_reg} + {1'b0, off_reg};
        phys_rd  = (phys_sum >= (BA_W + 1)'(BINS)) ? BA_W'(phys_sum - (BA_W + 1)'(BINS))
                                                   : phys_sum[BA_W-1:0];
        clr_sum  = {1'b0, clr_ptr_reg} + (BA_W + 1)'(1);
        clr_inc  = (clr_sum >= (BA_W + 1)'(BINS)) ? '0 : clr_sum[BA_W-1:0];
        rd_addr_sum = 32'(window_base_reg) + 32'(off_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctp_pkg::S_CLR:
            begin
                if (clr_left_reg == CL_W'(1))
                begin
                    state_next = clr_ret_reg;
                end
            end
            ctp_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.kind)
                        ctp_pkg::ACT_ENTRY: state_next = ctp_pkg::S_OUT;
                        ctp_pkg::ACT_EXIT:
                            state_next = (level_reg == '0) ? ctp_pkg::S_OUT : ctp_pkg::S_POP;
                        ctp_pkg::ACT_CLEAR: state_next = ctp_pkg::S_CLR;
                        ctp_pkg::ACT_READ:
                            state_next = q_cmd.idx_ok ? ctp_pkg::S_BIN_RD : ctp_pkg::S_OUT;
                        default: state_next = ctp_pkg::S_OUT;
                    endcase
                end
            end
            ctp_pkg::S_POP:    state_next = enabled ? ctp_pkg::S_CORR : ctp_pkg::S_OUT;
            ctp_pkg::S_CORR:   state_next = ctp_pkg::S_ELAP;
            ctp_pkg::S_ELAP:   state_next = ctp_pkg::S_REC;
            ctp_pkg::S_REC:
            begin
                if (below)
                begin
                    state_next = ctp_pkg::S_CLR;
                end
                else if (!shift_small)
                begin
                    state_next = ctp_pkg::S_OUT;
                end
                else
                begin
                    state_next = ctp_pkg::S_BIN_RD;
                end
            end
            ctp_pkg::S_BIN_RD:   state_next = ctp_pkg::S_BIN_DATA;
            ctp_pkg::S_BIN_DATA: state_next = ctp_pkg::S_OUT;
            ctp_pkg::S_OUT:
            begin
                if (load_out)
                begin
                    state_next = ctp_pkg::S_IDLE;
                end
            end
            default: state_next = ctp_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        q_pop            = 1'b0;
        cmd_next         = cmd_reg;
        res_next         = res_reg;
        clr_ret_next     = clr_ret_reg;
        level_next       = level_reg;
        slack_total_next = slack_total_reg;
        window_base_next = window_base_reg;
        base_known_next  = base_known_reg;
        phys_base_next   = phys_base_reg;
        clr_ptr_next     = clr_ptr_reg;
        clr_left_next    = clr_left_reg;
        off_next         = off_reg;
        phys_next        = phys_reg;
        faddr_next       = faddr_reg;
        dur_next         = dur_reg;
        fslack_next      = fslack_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        stk_we           = 1'b0;
        stk_re           = 1'b0;
        stk_waddr        = level_reg[SA_W-1:0];
        stk_raddr        = level_m1[SA_W-1:0];
        stk_wdata.addr   = q_cmd.faddr;
        stk_wdata.start  = q_cmd.ts;
        stk_wdata.slack  = slack_total_reg;
        bin_we           = 1'b0;
        bin_re           = 1'b0;
        bin_raddr        = phys_rd;
        bin_waddr        = clr_ptr_reg;
        bin_wdata        = '0;
        out_valid_next   = out_valid_reg;
        out_res_next     = out_res_reg;

        case (state_reg)
            ctp_pkg::S_CLR:
            begin
                bin_we        = 1'b1;
                clr_ptr_next  = clr_inc;
                clr_left_next = clr_left_reg - CL_W'(1);
            end
            ctp_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    res_next = '0;
                    off_next = BA_W'(32'(q_cmd.idx));
                    case (q_cmd.kind)
                        ctp_pkg::ACT_ENTRY:
                        begin
                            if (!enabled)
                            begin
                                res_next.status = ctp_pkg::STAT_DISABLED;
                            end
                            else if (level_reg >= SL_W'(STACK_DEPTH))
                            begin
                                res_next.status = ctp_pkg::STAT_OVERFLOW;
                            end
                            else
                            begin
                                stk_we     = 1'b1;
                                level_next = level_reg + SL_W'(1);
                            end
                        end
                        ctp_pkg::ACT_EXIT:
                        begin
                            if (level_reg == '0)
                            begin
                                res_next.status = ctp_pkg::STAT_UNDERFLOW;
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                level_next = level_m1;
                            end
                        end
                        ctp_pkg::ACT_CLEAR:
                        begin
                            window_base_next = '0;
                            base_known_next  = 1'b0;
                            clr_ptr_next     = '0;
                            clr_left_next    = CL_W'(BINS);
                            clr_ret_next     = ctp_pkg::S_OUT;
                        end
                        ctp_pkg::ACT_READ:
                        begin
                            if (!q_cmd.idx_ok)
                            begin
                                res_next.status = ctp_pkg::STAT_OUTSIDE;
                            end
                        end
                        default:
                        begin
                            res_next.status = ctp_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            ctp_pkg::S_POP:
            begin
                if (!enabled)
                begin
                    res_next.status = ctp_pkg::STAT_DISABLED;
                end
                else
                begin
                    slack_total_next = slack_total_reg + 64'(slack_per_pair);
                    dur_next         = cmd_reg.ts - stk_rdata.start;
                    fslack_next      = stk_rdata.slack;
                    faddr_next       = stk_rdata.addr;
                end
            end
            ctp_pkg::S_CORR:
            begin
                // elapsed = dur - (total - frame slack - caller share)
                x_next = dur_reg + 64'(caller_share);
                y_next = slack_total_reg - fslack_reg;
            end
            ctp_pkg::S_ELAP:
            begin
                res_next.elapsed = x_reg - y_reg;
            end
            ctp_pkg::S_REC:
            begin
                base_known_next = 1'b1;
                if (below)
                begin
                    window_base_next = key;
                    off_next         = '0;
                    clr_ret_next     = ctp_pkg::S_BIN_RD;
                    if (shift_small)
                    begin
                        phys_base_next = phys_dn;
                        clr_ptr_next   = phys_dn;
                        clr_left_next  = CL_W'(key_gap_lo);
                    end
                    else
                    begin
                        clr_ptr_next  = '0;
                        clr_left_next = CL_W'(BINS);
                    end
                end
                else
                begin
                    window_base_next = base_eff;
                    off_next         = key_gap_lo;
                    if (!shift_small)
                    begin
                        res_next.status = ctp_pkg::STAT_OUTSIDE;
                    end
                end
            end
            ctp_pkg::S_BIN_RD:
            begin
                bin_re    = 1'b1;
                phys_next = phys_rd;
            end
            ctp_pkg::S_BIN_DATA:
            begin
                if (cmd_reg.kind == ctp_pkg::ACT_READ)
                begin
                    res_next.rd_count = bin_rdata.count;
                    res_next.rd_time  = bin_rdata.total;
                    res_next.rd_addr  = 32'(rd_addr_sum << ALIGN_SHIFT);
                end
                else
                begin
                    bin_we          = 1'b1;
                    bin_waddr       = phys_reg;
                    bin_wdata.count = bin_rdata.count + ctp_pkg::COUNT_W'(1);
                    bin_wdata.total = bin_rdata.total + res_reg.elapsed;
                end
            end
            ctp_pkg::S_OUT:
            begin
                res_next.base_valid = base_known_reg;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase

        if (load_out)
        begin
            out_valid_next          = 1'b1;
            out_res_next            = res_reg;
            out_res_next.base_valid = base_known_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts with a sweep that zeroes every bin
            state_reg       <= ctp_pkg::S_CLR;
            clr_ret_reg     <= ctp_pkg::S_IDLE;
            clr_ptr_reg     <= '0;
            clr_left_reg    <= CL_W'(BINS);
            level_reg       <= '0;
            slack_total_reg <= '0;
            window_base_reg <= '0;
            base_known_reg  <= 1'b0;
            phys_base_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_ret_reg     <= clr_ret_next;
            clr_ptr_reg     <= clr_ptr_next;
            clr_left_reg    <= clr_left_next;
            level_reg       <= level_next;
            slack_total_reg <= slack_total_next;
            window_base_reg <= window_base_next;
            base_known_reg  <= base_known_next;
            phys_base_reg   <= phys_base_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
        off_reg     <= off_next;
        phys_reg    <= phys_next;
        faddr_reg   <= faddr_next;
        dur_reg     <= dur_next;
        fslack_reg  <= fslack_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= SL_W'(STACK_DEPTH))
        else $error("call stack level beyond depth");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ctp_pkg::S_IDLE) && !q_empty)
        else $error("queue popped outside idle or while empty");

    a_clr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ctp_pkg::S_CLR) |-> (clr_left_reg != '0))
        else $error("clear sweep with nothing left");

    a_bin_data_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ctp_pkg::S_BIN_DATA) |-> ($past(state_reg) == ctp_pkg::S_BIN_RD))
        else $error("bin data used without a read issued");

endmodule

// ===== rtl/core/call_timing_profiler.sv =====
// top level of the call timing profiler
// Events enter through a two-deep queue and are worked one at a time by the back end.
// The time an event takes is set by the frame read from the stack ram, the split 64-bit
// overhead correction and the read-modify-write of the bin ram. A clear action sweeps all
// BINS bins, and an exit that moves the window down clears the bins it uncovers (BINS at
// most), both one bin at a time through the bin ram's single write port. After reset a
// clearing pass zeroes the bins before the first event is worked; events and
// configuration writes are still accepted meanwhile.
module call_timing_profiler #(
    parameter int BINS        = ctp_pkg::BINS_DEF,
    parameter int ALIGN_SHIFT = ctp_pkg::ALIGN_SHIFT_DEF,
    parameter int STACK_DEPTH = ctp_pkg::STACK_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [111:0]                   s_axis_tdata,  // function_address, timestamp, bin_index
    input  logic [1:0]                     s_axis_tuser,  // action
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [191:0]                   m_axis_tdata,  // elapsed_corrected, read_count,
                                                          // read_time, read_address
    output logic [3:0]                     m_axis_tuser,  // status, base_valid
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctp_pkg::SLACK_W-1:0]    cfg_data
);

    logic                        enabled_reg;
    logic [ctp_pkg::SLACK_W-1:0] slack_pair_reg;
    logic [ctp_pkg::SLACK_W-1:0] slack_caller_reg;

    logic          q_full, q_push, q_empty, q_pop;
    ctp_pkg::cmd_t q_in, q_out;
    ctp_pkg::res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg      <= 1'b0;
            slack_pair_reg   <= ctp_pkg::SLACK_PAIR_RST;
            slack_caller_reg <= ctp_pkg::SLACK_CALLER_RST;
        end
        else if (cfg_valid)
        begin
            case (ctp_pkg::cfg_reg_t'(cfg_index))
                ctp_pkg::CFG_ENABLED:      enabled_reg      <= cfg_data[0];
                ctp_pkg::CFG_SLACK_PAIR:   slack_pair_reg   <= cfg_data;
                ctp_pkg::CFG_SLACK_CALLER: slack_caller_reg <= cfg_data;
                default:                   enabled_reg      <= enabled_reg;
            endcase
        end
    end

    ctp_front #(.BINS(BINS)) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_in)
    );

    ctp_fifo #(.WIDTH($bits(ctp_pkg::cmd_t)), .DEPTH(ctp_pkg::QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_out),
        .empty (q_empty)
    );

    ctp_back #(
        .BINS        (BINS),
        .ALIGN_SHIFT (ALIGN_SHIFT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .enabled        (enabled_reg),
        .slack_per_pair (slack_pair_reg),
        .caller_share   (slack_caller_reg),
        .q_empty        (q_empty),
        .q_cmd          (q_out),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_res        (res)
    );

    assign m_axis_tdata = {res.rd_addr, res.rd_time, res.rd_count, res.elapsed};
    assign m_axis_tuser = {res.base_valid, res.status};

endmodule
